FILE: hdl/vcrd_pkg.sv
`timescale 1ns / 1ps

package vcrd_pkg;

    localparam int NUM_THREADS    = 8;
    localparam int NUM_LOCKS      = 16;
    localparam int NUM_VARS       = 256;
    localparam int CLOCK_BITS_DEF = 32;

    localparam int OPW    = 3;
    localparam int TW     = 3;
    localparam int LW     = 4;
    localparam int VW     = 8;
    localparam int SITE_W = 32;

    typedef enum logic [OPW-1:0] {
        OP_READ    = 3'd0,
        OP_WRITE   = 3'd1,
        OP_FORK    = 3'd2,
        OP_JOIN    = 3'd3,
        OP_ACQUIRE = 3'd4,
        OP_RELEASE = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        RACE_WR = 2'd0,
        RACE_WW = 2'd1,
        RACE_RW = 2'd2,
        RACE_SW = 2'd3
    } race_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC_A,
        ST_ACC_B,
        ST_ACC_C,
        ST_SCAN,
        ST_EMIT,
        ST_ROW,
        ST_VEC,
        ST_TICK_RD,
        ST_TICK_WR
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [TW-1:0]     thread;
        logic [TW-1:0]     peer;
        logic [VW-1:0]     addr;
        logic [LW-1:0]     lock;
        logic [SITE_W-1:0] site;
    } cmd_t;

endpackage

FILE: hdl/vcrd_evt_if.sv
`timescale 1ns / 1ps

interface vcrd_evt_if import vcrd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OPW-1:0]    operation;
    logic [TW-1:0]     thread;
    logic [TW-1:0]     peer_thread;
    logic [VW-1:0]     var_address;
    logic [LW-1:0]     lock_index;
    logic [SITE_W-1:0] site_tag;

    modport source (output valid, operation, thread, peer_thread, var_address, lock_index,
                    site_tag, input ready);
    modport sink (input valid, operation, thread, peer_thread, var_address, lock_index,
                  site_tag, output ready);
endinterface

FILE: hdl/vcrd_race_if.sv
`timescale 1ns / 1ps

interface vcrd_race_if import vcrd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        race_kind;
    logic [TW-1:0]     racing_thread;
    logic [SITE_W-1:0] racing_site;
    logic [TW-1:0]     prior_thread;
    logic [SITE_W-1:0] prior_site;
    logic [VW-1:0]     race_address;
    logic              last_report;

    modport source (output valid, race_kind, racing_thread, racing_site, prior_thread,
                    prior_site, race_address, last_report, input ready);
    modport sink (input valid, race_kind, racing_thread, racing_site, prior_thread,
                  prior_site, race_address, last_report, output ready);
endinterface

FILE: hdl/vcrd_front.sv
`timescale 1ns / 1ps

module vcrd_front import vcrd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    vcrd_evt_if.sink evt,
    output cmd_t     cmd,
    output logic     cmd_valid,
    input  logic     cmd_pop
);

    localparam int QD  = 2;
    localparam int QAW = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);

    cmd_t           q_reg [QD];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] cnt_reg, cnt_next;
    logic           known;
    logic           push;
    cmd_t           entry;

    // Unknown operations are taken and dropped here; they never reach the back end.
    assign known     = evt.operation <= OPW'(OP_RELEASE);
    assign evt.ready = cnt_reg != QCW'(QD);
    assign push      = evt.valid && evt.ready && known;
    assign cmd       = q_reg[rd_ptr_reg];
    assign cmd_valid = cnt_reg != '0;

    always_comb
    begin
        entry.op     = op_t'(evt.operation);
        entry.thread = evt.thread;
        entry.peer   = evt.peer_thread;
        entry.addr   = evt.var_address;
        entry.lock   = evt.lock_index;
        entry.site   = evt.site_tag;
        wr_ptr_next  = push ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next  = cmd_pop ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        cnt_next     = cnt_reg + QCW'(push) - QCW'(cmd_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: hdl/vcrd_back.sv
`timescale 1ns / 1ps

module vcrd_back import vcrd_pkg::*;
#(
    parameter int CLOCK_BITS = CLOCK_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  logic        cmd_valid,
    output logic        cmd_pop,
    vcrd_race_if.source race
);

    localparam int TAW = 2 * TW;
    localparam int LAW = LW + TW;
    localparam int RAW = VW + TW;
    localparam int CW  = TW + 1;
    localparam int NT  = NUM_THREADS * NUM_THREADS;
    localparam int NL  = NUM_LOCKS * NUM_THREADS;
    localparam int NR  = NUM_VARS * NUM_THREADS;

    typedef struct packed {
        logic [TW-1:0]         rt;
        logic [CLOCK_BITS-1:0] rclk;
        logic [SITE_W-1:0]     rsite;
        logic [TW-1:0]         wt;
        logic [CLOCK_BITS-1:0] wclk;
        logic [SITE_W-1:0]     wsite;
        logic                  sh;
    } var_ent_t;

    // Thread clocks: row is the owning thread, column the entry.
    logic [CLOCK_BITS-1:0] tmem [NT];
    logic [NT-1:0]         tvalid_reg;
    logic [TAW-1:0]        ta_addr, tb_addr, tw_addr, ta_addr_reg, tb_addr_reg;
    logic [CLOCK_BITS-1:0] ta_data_reg, tb_data_reg, tw_data, ta_val, tb_val;
    logic                  ta_vld_reg, tb_vld_reg, tw_en;

    logic [CLOCK_BITS-1:0] lmem [NL];
    logic [NL-1:0]         lvalid_reg;
    logic [LAW-1:0]        la_addr, lw_addr;
    logic [CLOCK_BITS-1:0] la_data_reg, lw_data, la_val;
    logic                  la_vld_reg, lw_en;

    var_ent_t              vmem [NUM_VARS];
    logic [NUM_VARS-1:0]   vvalid_reg;
    var_ent_t              v_data_reg, v_ent, vw_data;
    logic                  v_vld_reg, vw_en;

    logic [CLOCK_BITS-1:0] rcmem [NR];
    logic [RAW-1:0]        ra_addr, rw_addr;
    logic [CLOCK_BITS-1:0] ra_data_reg, rw_data;
    logic                  rw_en;

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  pend_reg, pend_next;
    logic [TW-1:0]         wi_reg, wi_next;
    logic [CLOCK_BITS-1:0] clk_reg, clk_next;
    logic [TW-1:0]         rt_reg, rt_next;
    logic [CLOCK_BITS-1:0] rclk_reg, rclk_next;
    logic [SITE_W-1:0]     rsite_reg, rsite_next;
    logic                  late_reg, late_next;
    logic [1:0]            n_reg, n_next, n_tmp;
    race_t                 rep_kind_reg [2], rep_kind_next [2];
    logic [TW-1:0]         rep_thr_reg [2], rep_thr_next [2];
    logic [SITE_W-1:0]     rep_site_reg [2], rep_site_next [2];
    logic                  e_idx_reg, e_idx_next;
    logic                  row_after_reg, row_after_next;

    logic                  o_valid_reg, o_valid_next;
    race_t                 o_kind_reg, o_kind_next;
    logic [TW-1:0]         o_thr_reg, o_thr_next, o_pthr_reg, o_pthr_next;
    logic [SITE_W-1:0]     o_site_reg, o_site_next, o_psite_reg, o_psite_next;
    logic [VW-1:0]         o_addr_reg, o_addr_next;
    logic                  o_last_reg, o_last_next;

    logic [TW-1:0]         t, p, src_thr, dst_thr, idx;
    logic [CLOCK_BITS-1:0] src_val;
    logic                  wrace, rrace, same_rd, same_wr;

    assign race.valid         = o_valid_reg;
    assign race.race_kind     = o_kind_reg;
    assign race.racing_thread = o_thr_reg;
    assign race.racing_site   = o_site_reg;
    assign race.prior_thread  = o_pthr_reg;
    assign race.prior_site    = o_psite_reg;
    assign race.race_address  = o_addr_reg;
    assign race.last_report   = o_last_reg;

    assign t   = cmd_reg.thread;
    assign p   = cmd_reg.peer;
    assign idx = cnt_reg[TW-1:0];

    // An entry never written reads as its reset value.
    assign ta_val = ta_vld_reg ? ta_data_reg :
                    CLOCK_BITS'(ta_addr_reg[TAW-1:TW] == ta_addr_reg[TW-1:0]);
    assign tb_val = tb_vld_reg ? tb_data_reg :
                    CLOCK_BITS'(tb_addr_reg[TAW-1:TW] == tb_addr_reg[TW-1:0]);
    assign la_val = la_vld_reg ? la_data_reg : '0;
    assign v_ent  = v_vld_reg ? v_data_reg : '0;

    assign wrace   = v_ent.wclk > ta_val;
    assign rrace   = v_ent.rclk > tb_val;
    // A read clock row holds data only while the shared flag is set.
    assign same_rd = (v_ent.rt == t && v_ent.rclk == clk_reg) ||
                     (v_ent.sh && ra_data_reg == clk_reg);
    assign same_wr = v_ent.wt == t && v_ent.wclk == clk_reg;

    assign src_thr = (cmd_reg.op == OP_JOIN) ? p : t;
    assign dst_thr = (cmd_reg.op == OP_FORK) ? p : t;
    assign src_val = (cmd_reg.op == OP_ACQUIRE) ? la_val : ta_val;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        wi_next        = wi_reg;
        clk_next       = clk_reg;
        rt_next        = rt_reg;
        rclk_next      = rclk_reg;
        rsite_next     = rsite_reg;
        late_next      = late_reg;
        n_next         = n_reg;
        n_tmp          = '0;
        rep_kind_next  = rep_kind_reg;
        rep_thr_next   = rep_thr_reg;
        rep_site_next  = rep_site_reg;
        e_idx_next     = e_idx_reg;
        row_after_next = row_after_reg;
        o_valid_next   = o_valid_reg && !race.ready;
        o_kind_next    = o_kind_reg;
        o_thr_next     = o_thr_reg;
        o_site_next    = o_site_reg;
        o_pthr_next    = o_pthr_reg;
        o_psite_next   = o_psite_reg;
        o_addr_next    = o_addr_reg;
        o_last_next    = o_last_reg;
        cmd_pop        = 1'b0;
        ta_addr        = {t, t};
        tb_addr        = {t, t};
        la_addr        = {cmd_reg.lock, idx};
        ra_addr        = {cmd_reg.addr, t};
        tw_en          = 1'b0;
        tw_addr        = {t, t};
        tw_data        = (ta_val == '1) ? ta_val : ta_val + CLOCK_BITS'(1);
        lw_en          = 1'b0;
        lw_addr        = {cmd_reg.lock, wi_reg};
        lw_data        = ta_val;
        vw_en          = 1'b0;
        vw_data        = v_ent;
        rw_en          = 1'b0;
        rw_addr        = {cmd_reg.addr, t};
        rw_data        = clk_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    cnt_next = '0;
                    case (cmd.op)
                        OP_READ, OP_WRITE:
                        begin
                            state_next = ST_ACC_A;
                        end
                        OP_FORK, OP_JOIN, OP_ACQUIRE, OP_RELEASE:
                        begin
                            state_next = ST_VEC;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_ACC_A:
            begin
                state_next = ST_ACC_B;
            end

            ST_ACC_B:
            begin
                clk_next   = ta_val;
                ta_addr    = {t, v_ent.wt};
                tb_addr    = {t, v_ent.rt};
                state_next = ST_ACC_C;
            end

            ST_ACC_C:
            begin
                rt_next        = v_ent.rt;
                rclk_next      = v_ent.rclk;
                rsite_next     = v_ent.rsite;
                e_idx_next     = 1'b0;
                late_next      = 1'b0;
                row_after_next = 1'b0;
                cnt_next       = '0;
                n_next         = '0;
                state_next     = ST_IDLE;
                if (cmd_reg.op == OP_READ)
                begin
                    if (!same_rd)
                    begin
                        vw_en          = 1'b1;
                        vw_data.rt     = t;
                        vw_data.rclk   = clk_reg;
                        vw_data.rsite  = cmd_reg.site;
                        vw_data.sh     = v_ent.sh || rrace;
                        rw_en          = v_ent.sh;
                        row_after_next = !v_ent.sh && rrace;
                        if (wrace)
                        begin
                            rep_kind_next[0] = RACE_WR;
                            rep_thr_next[0]  = v_ent.wt;
                            rep_site_next[0] = v_ent.wsite;
                            n_next           = 2'd1;
                            state_next       = ST_EMIT;
                        end
                        else if (!v_ent.sh && rrace)
                        begin
                            state_next = ST_ROW;
                        end
                    end
                end
                else if (!same_wr)
                begin
                    vw_en         = 1'b1;
                    vw_data.wt    = t;
                    vw_data.wclk  = clk_reg;
                    vw_data.wsite = cmd_reg.site;
                    if (v_ent.sh)
                    begin
                        vw_data.rt    = '0;
                        vw_data.rclk  = '0;
                        vw_data.rsite = '0;
                        vw_data.sh    = 1'b0;
                    end
                    if (wrace)
                    begin
                        rep_kind_next[0] = RACE_WW;
                        rep_thr_next[0]  = v_ent.wt;
                        rep_site_next[0] = v_ent.wsite;
                        n_tmp            = 2'd1;
                    end
                    if (!v_ent.sh && rrace)
                    begin
                        rep_kind_next[n_tmp[0]] = RACE_RW;
                        rep_thr_next[n_tmp[0]]  = v_ent.rt;
                        rep_site_next[n_tmp[0]] = v_ent.rsite;
                        n_tmp                   = n_tmp + 2'd1;
                    end
                    n_next = n_tmp;
                    if (v_ent.sh)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (n_tmp != '0)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_SCAN:
            begin
                ra_addr = {cmd_reg.addr, idx};
                tb_addr = {t, idx};
                if (pend_reg && ra_data_reg > tb_val)
                begin
                    late_next = 1'b1;
                end
                if (cnt_reg != CW'(NUM_THREADS))
                begin
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg + CW'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = (n_reg != '0) ? ST_EMIT : ST_IDLE;
                    if (late_reg)
                    begin
                        rep_kind_next[n_reg[0]] = RACE_SW;
                        rep_thr_next[n_reg[0]]  = rt_reg;
                        rep_site_next[n_reg[0]] = rsite_reg;
                        n_next                  = n_reg + 2'd1;
                        state_next              = ST_EMIT;
                    end
                end
            end

            ST_EMIT:
            begin
                if (!o_valid_reg || race.ready)
                begin
                    o_valid_next = 1'b1;
                    o_kind_next  = rep_kind_reg[e_idx_reg];
                    o_pthr_next  = rep_thr_reg[e_idx_reg];
                    o_psite_next = rep_site_reg[e_idx_reg];
                    o_thr_next   = t;
                    o_site_next  = cmd_reg.site;
                    o_addr_next  = cmd_reg.addr;
                    o_last_next  = {1'b0, e_idx_reg} == n_reg - 2'd1;
                    e_idx_next   = !e_idx_reg;
                    if ({1'b0, e_idx_reg} == n_reg - 2'd1)
                    begin
                        cnt_next   = '0;
                        state_next = row_after_reg ? ST_ROW : ST_IDLE;
                    end
                end
            end

            ST_ROW:
            begin
                // The read becomes shared: the whole row is rewritten.
                rw_en   = 1'b1;
                rw_addr = {cmd_reg.addr, idx};
                if (idx == t)
                begin
                    rw_data = clk_reg;
                end
                else if (idx == rt_reg)
                begin
                    rw_data = rclk_reg;
                end
                else
                begin
                    rw_data = '0;
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(NUM_THREADS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_VEC:
            begin
                ta_addr = {src_thr, idx};
                tb_addr = {dst_thr, idx};
                if (pend_reg)
                begin
                    if (cmd_reg.op == OP_RELEASE)
                    begin
                        lw_en = 1'b1;
                    end
                    else
                    begin
                        tw_en   = 1'b1;
                        tw_addr = {dst_thr, wi_reg};
                        tw_data = (src_val > tb_val) ? src_val : tb_val;
                    end
                end
                if (cnt_reg != CW'(NUM_THREADS))
                begin
                    pend_next = 1'b1;
                    wi_next   = idx;
                    cnt_next  = cnt_reg + CW'(1);
                end
                else if (!pend_reg)
                begin
                    if (cmd_reg.op == OP_FORK || cmd_reg.op == OP_RELEASE)
                    begin
                        state_next = ST_TICK_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_TICK_RD:
            begin
                state_next = ST_TICK_WR;
            end

            ST_TICK_WR:
            begin
                tw_en      = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tw_en)
        begin
            tmem[tw_addr] <= tw_data;
        end
        ta_data_reg <= tmem[ta_addr];
        tb_data_reg <= tmem[tb_addr];
        ta_addr_reg <= ta_addr;
        tb_addr_reg <= tb_addr;
        if (lw_en)
        begin
            lmem[lw_addr] <= lw_data;
        end
        la_data_reg <= lmem[la_addr];
        if (vw_en)
        begin
            vmem[cmd_reg.addr] <= vw_data;
        end
        v_data_reg <= vmem[cmd_reg.addr];
        if (rw_en)
        begin
            rcmem[rw_addr] <= rw_data;
        end
        ra_data_reg <= rcmem[ra_addr];
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        cnt_reg       <= cnt_next;
        wi_reg        <= wi_next;
        clk_reg       <= clk_next;
        rt_reg        <= rt_next;
        rclk_reg      <= rclk_next;
        rsite_reg     <= rsite_next;
        late_reg      <= late_next;
        n_reg         <= n_next;
        rep_kind_reg  <= rep_kind_next;
        rep_thr_reg   <= rep_thr_next;
        rep_site_reg  <= rep_site_next;
        e_idx_reg     <= e_idx_next;
        row_after_reg <= row_after_next;
        o_kind_reg    <= o_kind_next;
        o_thr_reg     <= o_thr_next;
        o_site_reg    <= o_site_next;
        o_pthr_reg    <= o_pthr_next;
        o_psite_reg   <= o_psite_next;
        o_addr_reg    <= o_addr_next;
        o_last_reg    <= o_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            o_valid_reg <= 1'b0;
            tvalid_reg  <= '0;
            lvalid_reg  <= '0;
            vvalid_reg  <= '0;
            ta_vld_reg  <= 1'b0;
            tb_vld_reg  <= 1'b0;
            la_vld_reg  <= 1'b0;
            v_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            o_valid_reg <= o_valid_next;
            if (tw_en)
            begin
                tvalid_reg[tw_addr] <= 1'b1;
            end
            if (lw_en)
            begin
                lvalid_reg[lw_addr] <= 1'b1;
            end
            if (vw_en)
            begin
                vvalid_reg[cmd_reg.addr] <= 1'b1;
            end
            ta_vld_reg <= tvalid_reg[ta_addr];
            tb_vld_reg <= tvalid_reg[tb_addr];
            la_vld_reg <= lvalid_reg[la_addr];
            v_vld_reg  <= vvalid_reg[cmd_reg.addr];
        end
    end

endmodule

FILE: hdl/vector_clock_race_detector.sv
`timescale 1ns / 1ps

// FastTrack race detector for 8 threads, 16 locks and 256 variable slots. Events enter a
// two-entry queue and are carried out one at a time by a sequencer over memories with
// registered reads for thread clocks, lock clocks, variable epochs and read clocks. A read or
// write passes ACC_A, ACC_B and ACC_C and one emit state per race report, which waits while
// the race output stalls. A read that turns a variable shared then rewrites its read clock
// row; a write to a shared variable compares its row entry by entry. Fork, join, acquire
// and release walk the 8 vector clock entries through a read-then-write pipeline; fork and
// release then increment the thread clock. Unknown operations are dropped at the queue. No
// clearing pass follows reset; all state reads as its reset value at once.
module vector_clock_race_detector import vcrd_pkg::*;
#(
    parameter int CLOCK_BITS = CLOCK_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    vcrd_evt_if.sink    evt,
    vcrd_race_if.source race
);

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;

    vcrd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    vcrd_back #(.CLOCK_BITS(CLOCK_BITS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .race      (race)
    );

endmodule
